// ===== src/bbs_pkg.sv =====
// Shared types and constants of the byte buffer bit shifter.
// Used by every module of the block; depends on nothing.
package bbs_pkg;

  localparam int DEFAULT_BUFFER_BYTES = 64;
  localparam int MAX_BUFFER_BYTES     = 64;
  // Wide enough to hold a byte count up to the largest buffer.
  localparam int CNT_W                = $clog2(MAX_BUFFER_BYTES + 1);
  localparam int SHIFT_W              = 17;
  localparam int BYTE_W               = 8;
  // Two queue entries, one per RAM bank: the buffer being emitted and the next.
  localparam int Q_DEPTH              = 2;

  typedef struct packed {
    logic             bank;      // RAM bank that holds the buffer
    logic [CNT_W-1:0] n;         // bytes held
    logic             zero_all;  // shift magnitude covers the whole buffer
    logic             right;     // shift toward the last byte
    logic [CNT_W-1:0] q;         // whole-byte part of the shift
    logic [2:0]       r;         // bit part of the shift
    logic             ovf;       // bytes were dropped
  } cmd_t;

endpackage

// ===== src/byte_buffer_bit_shifter.sv =====
// Top level of the byte buffer bit shifter: input side, command queue,
// two-bank RAM and output side. Depends on bbs_pkg and the bbs_* modules.
//
//   channel   dir   tdata (low bit up)               tlast       tuser
//   s_*       in    data_byte[7:0], shift_bits[24:8] last_byte   -
//   m_*       out   out_byte[7:0]                    last_out    too_long
//
// Input beats are taken one per cycle while s_tready is high; the last beat of
// a buffer queues it. Output bytes follow one per cycle unless m_tready stalls;
// the first comes from the registered RAM read of the buffer at the queue head.
// Two buffers may be pending at once; while both RAM banks are held, s_tready
// is low. Reset (rst, synchronous) empties the queue and the byte counter.
// A stall on m_tready holds the output beat and pauses the RAM reads.
module byte_buffer_bit_shifter #(
  parameter int BUFFER_BYTES = bbs_pkg::DEFAULT_BUFFER_BYTES
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // data_byte[7:0], shift_bits[24:8], zero fill
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // out_byte[7:0]
  output logic        m_tlast,
  output logic        m_tuser    // too_long[0]
);

  localparam int IDX_W = (BUFFER_BYTES > 1) ? $clog2(BUFFER_BYTES) : 1;

  logic          q_full;
  logic          q_empty;
  logic          q_push;
  logic          q_pop;
  bbs_pkg::cmd_t push_cmd;
  bbs_pkg::cmd_t head;
  logic          wr_en;
  logic [IDX_W:0] wr_addr;
  logic [7:0]    wr_data;
  logic          rd_en;
  logic [IDX_W:0] rd_addr_up;
  logic [IDX_W:0] rd_addr_lo;
  logic [7:0]    rd_data_up;
  logic [7:0]    rd_data_lo;

  bbs_front #(
    .BUFFER_BYTES (BUFFER_BYTES),
    .IDX_W        (IDX_W)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .data_byte  (s_tdata[7:0]),
    .last_byte  (s_tlast),
    .shift_bits (s_tdata[24:8]),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_cmd      (push_cmd),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .wr_data    (wr_data)
  );

  bbs_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_cmd (push_cmd),
    .pop      (q_pop),
    .head     (head),
    .empty    (q_empty),
    .full     (q_full)
  );

  bbs_ram #(
    .ADDR_W (IDX_W + 1)
  ) u_ram (
    .clk        (clk),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .wr_data    (wr_data),
    .rd_en      (rd_en),
    .rd_addr_up (rd_addr_up),
    .rd_addr_lo (rd_addr_lo),
    .rd_data_up (rd_data_up),
    .rd_data_lo (rd_data_lo)
  );

  bbs_back #(
    .IDX_W (IDX_W)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .q_empty    (q_empty),
    .q_pop      (q_pop),
    .rd_en      (rd_en),
    .rd_addr_up (rd_addr_up),
    .rd_addr_lo (rd_addr_lo),
    .rd_data_up (rd_data_up),
    .rd_data_lo (rd_data_lo),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .out_byte   (m_tdata),
    .last_out   (m_tlast),
    .too_long   (m_tuser)
  );

endmodule

// ===== src/bbs_ram.sv =====
// Two-bank byte RAM: one write port, two registered read ports.
// Depends on bbs_pkg.
module bbs_ram #(
  parameter int ADDR_W = 7
) (
  input  logic                       clk,
  input  logic                       wr_en,
  input  logic [ADDR_W-1:0]          wr_addr,
  input  logic [bbs_pkg::BYTE_W-1:0] wr_data,
  input  logic                       rd_en,
  input  logic [ADDR_W-1:0]          rd_addr_up,
  input  logic [ADDR_W-1:0]          rd_addr_lo,
  output logic [bbs_pkg::BYTE_W-1:0] rd_data_up,
  output logic [bbs_pkg::BYTE_W-1:0] rd_data_lo
);

  logic [bbs_pkg::BYTE_W-1:0] mem [2**ADDR_W];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_up <= mem[rd_addr_up];
      rd_data_lo <= mem[rd_addr_lo];
    end
  end

endmodule

// ===== src/bbs_front.sv =====
// Input side: stores incoming bytes into the free RAM bank and, on the last
// beat, classifies the shift and pushes a command. Depends on bbs_pkg.
module bbs_front #(
  parameter int BUFFER_BYTES = bbs_pkg::DEFAULT_BUFFER_BYTES,
  parameter int IDX_W        = 6
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [bbs_pkg::BYTE_W-1:0]  data_byte,
  input  logic                        last_byte,
  input  logic [bbs_pkg::SHIFT_W-1:0] shift_bits,
  input  logic                        q_full,
  output logic                        q_push,
  output bbs_pkg::cmd_t               q_cmd,
  output logic                        wr_en,
  output logic [IDX_W:0]              wr_addr,
  output logic [bbs_pkg::BYTE_W-1:0]  wr_data
);

  logic [bbs_pkg::CNT_W-1:0]   count;
  logic                        ovf;
  logic                        wbank;
  logic                        accept;
  logic                        room;
  logic [bbs_pkg::CNT_W-1:0]   n_after;
  logic                        ovf_after;
  logic [bbs_pkg::SHIFT_W-1:0] mag;
  logic [bbs_pkg::CNT_W+2:0]   nbits;

  assign s_tready  = !q_full;
  assign accept    = s_tvalid && s_tready;
  assign room      = count < bbs_pkg::CNT_W'(BUFFER_BYTES);
  assign n_after   = room ? count + bbs_pkg::CNT_W'(1) : count;
  assign ovf_after = ovf || !room;

  assign wr_en   = accept && room;
  assign wr_addr = {wbank, count[IDX_W-1:0]};
  assign wr_data = data_byte;

  // The most negative count wraps to a magnitude of 65536, which still fits.
  assign mag   = shift_bits[bbs_pkg::SHIFT_W-1] ? (bbs_pkg::SHIFT_W'(0) - shift_bits)
                                                : shift_bits;
  assign nbits = {n_after, 3'b000};

  always_comb begin
    q_cmd.bank     = wbank;
    q_cmd.n        = n_after;
    q_cmd.zero_all = mag >= bbs_pkg::SHIFT_W'(nbits);
    q_cmd.right    = shift_bits[bbs_pkg::SHIFT_W-1];
    q_cmd.q        = mag[bbs_pkg::CNT_W+2:3];
    q_cmd.r        = mag[2:0];
    q_cmd.ovf      = ovf_after;
  end

  assign q_push = accept && last_byte;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      ovf   <= 1'b0;
      wbank <= 1'b0;
    end else if (accept) begin
      if (last_byte) begin
        count <= '0;
        ovf   <= 1'b0;
        wbank <= !wbank;
      end else begin
        count <= n_after;
        ovf   <= ovf_after;
      end
    end
  end

endmodule

// ===== src/bbs_queue.sv =====
// Two-entry command queue between the input side and the output side.
// Depends on bbs_pkg.
module bbs_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  bbs_pkg::cmd_t push_cmd,
  input  logic          pop,
  output bbs_pkg::cmd_t head,
  output logic          empty,
  output logic          full
);

  localparam int PTR_W = $clog2(bbs_pkg::Q_DEPTH);
  localparam int LVL_W = $clog2(bbs_pkg::Q_DEPTH + 1);

  bbs_pkg::cmd_t    entries [bbs_pkg::Q_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [LVL_W-1:0] level;

  assign empty = level == '0;
  assign full  = level == LVL_W'(bbs_pkg::Q_DEPTH);
  assign head  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      unique case ({push, pop})
        2'b10:   level <= level + LVL_W'(1);
        2'b01:   level <= level - LVL_W'(1);
        default: level <= level;
      endcase
    end
  end

  a_no_push_full: assert property (@(posedge clk) disable iff (rst) !(push && full))
    else $error("command pushed into a full queue");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst) !(pop && empty))
    else $error("command popped from an empty queue");
  a_level_range: assert property (@(posedge clk) disable iff (rst)
    level <= LVL_W'(bbs_pkg::Q_DEPTH))
    else $error("queue level out of range");

endmodule

// ===== src/bbs_back.sv =====
// Output side: walks the buffer at the queue head, reads the two source bytes
// of each output byte and merges them. Depends on bbs_pkg.
module bbs_back #(
  parameter int IDX_W = 6
) (
  input  logic                       clk,
  input  logic                       rst,
  input  bbs_pkg::cmd_t              head,
  input  logic                       q_empty,
  output logic                       q_pop,
  output logic                       rd_en,
  output logic [IDX_W:0]             rd_addr_up,
  output logic [IDX_W:0]             rd_addr_lo,
  input  logic [bbs_pkg::BYTE_W-1:0] rd_data_up,
  input  logic [bbs_pkg::BYTE_W-1:0] rd_data_lo,
  output logic                       m_tvalid,
  input  logic                       m_tready,
  output logic [bbs_pkg::BYTE_W-1:0] out_byte,
  output logic                       last_out,
  output logic                       too_long
);

  logic [bbs_pkg::CNT_W-1:0] idx;
  logic                      advance;
  logic                      issue;
  logic                      beat_last;
  logic [bbs_pkg::CNT_W:0]   l_sum;
  logic [bbs_pkg::CNT_W:0]   l_sum1;
  logic [bbs_pkg::CNT_W-1:0] r_diff;
  logic [bbs_pkg::CNT_W-1:0] r_diff1;
  logic                      up_ok_c;
  logic                      lo_ok_c;
  logic [IDX_W-1:0]          up_idx;
  logic [IDX_W-1:0]          lo_idx;
  logic [3:0]                shamt_c;
  logic                      up_ok;
  logic                      lo_ok;
  logic [3:0]                shamt;
  logic [2*bbs_pkg::BYTE_W-1:0] word;

  assign advance   = !m_tvalid || m_tready;
  assign issue     = advance && !q_empty;
  assign beat_last = (idx + bbs_pkg::CNT_W'(1)) == head.n;
  assign q_pop     = issue && beat_last;

  // Left shift takes bytes i+q and i+q+1; right shift takes i-q-1 and i-q.
  assign l_sum   = {1'b0, idx} + {1'b0, head.q};
  assign l_sum1  = l_sum + (bbs_pkg::CNT_W + 1)'(1);
  assign r_diff  = idx - head.q;
  assign r_diff1 = r_diff - bbs_pkg::CNT_W'(1);

  always_comb begin
    if (head.zero_all) begin
      up_ok_c = 1'b0;
      lo_ok_c = 1'b0;
      up_idx  = l_sum[IDX_W-1:0];
      lo_idx  = l_sum1[IDX_W-1:0];
    end else if (!head.right) begin
      up_ok_c = l_sum < {1'b0, head.n};
      lo_ok_c = l_sum1 < {1'b0, head.n};
      up_idx  = l_sum[IDX_W-1:0];
      lo_idx  = l_sum1[IDX_W-1:0];
    end else begin
      lo_ok_c = idx >= head.q;
      up_ok_c = lo_ok_c && (r_diff != '0);
      up_idx  = r_diff1[IDX_W-1:0];
      lo_idx  = r_diff[IDX_W-1:0];
    end
    // A right shift by r is the byte pair moved left by 8-r.
    shamt_c = head.right ? 4'd8 - {1'b0, head.r} : {1'b0, head.r};
  end

  assign rd_en      = issue;
  assign rd_addr_up = {head.bank, up_idx};
  assign rd_addr_lo = {head.bank, lo_idx};

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      idx      <= '0;
    end else if (issue) begin
      m_tvalid <= 1'b1;
      idx      <= beat_last ? '0 : idx + bbs_pkg::CNT_W'(1);
    end else if (advance) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      up_ok    <= up_ok_c;
      lo_ok    <= lo_ok_c;
      shamt    <= shamt_c;
      last_out <= beat_last;
      too_long <= head.ovf;
    end
  end

  assign word     = {(up_ok ? rd_data_up : 8'h00), (lo_ok ? rd_data_lo : 8'h00)} << shamt;
  assign out_byte = word[2*bbs_pkg::BYTE_W-1:bbs_pkg::BYTE_W];

endmodule
